// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the dcc packet decoder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define DPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dcc decoder assertion failed");

// condition must never be true outside reset
`define DPD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dcc decoder forbidden condition seen");

`else

`define DPD_ASSERT(lbl, clk, rst_n, prop)
`define DPD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hdl/dcc_pid_pkg.sv =====
// ---------------------------------------------------------------------------
// dcc_pid_pkg
// types, opcodes and defaults shared by the dcc packet decoder
// ---------------------------------------------------------------------------
package dcc_pid_pkg;

	localparam int CV_COUNT_DEF = 256;
	localparam logic [7:0] HIGHEST_CV_RST = 8'd255;

	localparam logic [7:0] SVC_MASK     = 8'hF0;
	localparam logic [7:0] SVC_DIRECT   = 8'h70;
	localparam logic [7:0] KIND_MASK    = 8'hFC;
	localparam logic [7:0] KIND_VERIFY  = 8'h74;
	localparam logic [7:0] KIND_WRITE   = 8'h7C;
	localparam logic [7:0] KIND_BIT     = 8'h78;
	localparam logic [7:0] INSTR_MASK   = 8'hE0;
	localparam logic [7:0] INSTR_ADV    = 8'h20;
	localparam logic [7:0] INSTR_FG1    = 8'h80;
	localparam logic [7:0] INSTR_FG2    = 8'hA0;
	localparam logic [7:0] INSTR_CV     = 8'hE0;
	localparam logic [7:0] ADV_SUB_MASK = 8'h1F;
	localparam logic [7:0] ADV_SPEED128 = 8'h1F;
	localparam logic [7:0] CV_OP_MASK   = 8'h0C;
	localparam logic [7:0] CV_OP_WRITE  = 8'h0C;

	localparam logic [2:0] SIZE_RESET = 3'd3;
	localparam logic [2:0] SIZE_SVC   = 3'd4;
	localparam logic [2:0] SIZE_LONG  = 3'd5;

	typedef enum logic [1:0] {
		PH_INACTIVE = 2'd0,
		PH_POSSIBLE = 2'd1,
		PH_ACTIVE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0] packet_size;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
	} pkt_t;

	typedef struct packed {
		logic       ack;
		logic       reset_seen;
		logic       speed_valid;
		logic [6:0] speed_step;
		logic       forward;
		logic       group1_valid;
		logic       group2_valid;
		logic [7:0] function_byte;
	} res_t;

	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} cv_wr_t;

endpackage

// ===== hdl/dcc_packet_instruction_decoder_core.sv =====
// ---------------------------------------------------------------------------
// dcc_packet_instruction_decoder_core
// dcc packet decoder with service-mode cv programming: one packet in, one
// result out, cv store read at accept and written when the packet retires
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid / in_ready     | packet_size, byte0..byte3
//  out      | out_valid / out_ready   | ack, reset_seen, speed_valid, speed_step,
//           |                         | forward, group1_valid, group2_valid,
//           |                         | function_byte
//  cfg      | cfg_we (no wait)        | cfg_data -> highest_cv
//
//  one item per cycle while out_ready keeps the output moving; from accept to
//  out_valid the cv store read is registered, then decode writes the result register
//  a stalled output holds the decode stage, in_ready drops once both are full
//  reset clears phase to inactive, highest_cv to 255 and all cv valid bits
//  at once, so the block accepts items in the first cycle after reset
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dcc_packet_instruction_decoder_core #(
	parameter int CV_COUNT = dcc_pid_pkg::CV_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] packet_size,
	input  logic [7:0] byte0,
	input  logic [7:0] byte1,
	input  logic [7:0] byte2,
	input  logic [7:0] byte3,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       ack,
	output logic       reset_seen,
	output logic       speed_valid,
	output logic [6:0] speed_step,
	output logic       forward,
	output logic       group1_valid,
	output logic       group2_valid,
	output logic [7:0] function_byte
);
	import dcc_pid_pkg::*;

	logic       valid_s1;
	pkt_t       pkt_s1;
	logic       out_valid_q;
	res_t       res_q;
	phase_t     phase_q;
	logic [7:0] highest_cv_q;

	logic       s1_adv;
	logic       accept;
	logic [7:0] cv_val;
	res_t       res_d;
	cv_wr_t     wr_d;
	cv_wr_t     wr;
	phase_t     phase_d;

	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	always_comb begin
		wr    = wr_d;
		wr.en = wr_d.en && s1_adv;
	end

	dcc_pid_cv_store #(
		.CV_COUNT(CV_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (byte1 + 8'd1),
		.wr      (wr),
		.rd_data (cv_val)
	);

	dcc_pid_decode #(
		.CV_COUNT(CV_COUNT)
	) u_decode (
		.pkt        (pkt_s1),
		.phase      (phase_q),
		.highest_cv (highest_cv_q),
		.cv_val     (cv_val),
		.res        (res_d),
		.wr         (wr_d),
		.phase_nxt  (phase_d)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_s1 <= '{packet_size: packet_size, byte0: byte0, byte1: byte1,
				byte2: byte2, byte3: byte3};
		end
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			phase_q      <= PH_INACTIVE;
			highest_cv_q <= HIGHEST_CV_RST;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				highest_cv_q <= cfg_data;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign ack           = res_q.ack;
	assign reset_seen    = res_q.reset_seen;
	assign speed_valid   = res_q.speed_valid;
	assign speed_step    = res_q.speed_step;
	assign forward       = res_q.forward;
	assign group1_valid  = res_q.group1_valid;
	assign group2_valid  = res_q.group2_valid;
	assign function_byte = res_q.function_byte;

	`DPD_ASSERT(a_phase_active_after_reset, clk, arst_n, (phase_q == PH_ACTIVE && $past(phase_q) == PH_POSSIBLE) |-> $past(s1_adv && res_d.reset_seen))
	`DPD_NEVER(a_ack_excl_decode, clk, arst_n, out_valid_q && res_q.ack && (res_q.speed_valid || res_q.group1_valid || res_q.group2_valid))
	`DPD_NEVER(a_reset_excl, clk, arst_n, out_valid_q && res_q.reset_seen && (res_q.ack || res_q.speed_valid || res_q.group1_valid || res_q.group2_valid))
	`DPD_NEVER(a_cv_write_only_on_retire, clk, arst_n, wr_d.en && s1_adv && (phase_q == PH_POSSIBLE))

endmodule

// ===== hdl/dcc_pid_cv_store.sv =====
// ---------------------------------------------------------------------------
// dcc_pid_cv_store
// cv byte store: one write and one registered read per cycle, entry valid
// bits so unwritten cvs read as zero, bypass of a same-cycle write
// ---------------------------------------------------------------------------
module dcc_pid_cv_store #(
	parameter int CV_COUNT = dcc_pid_pkg::CV_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [7:0]          rd_addr,
	input  dcc_pid_pkg::cv_wr_t wr,
	output logic [7:0]          rd_data
);
	import dcc_pid_pkg::*;

	localparam int AW = $clog2(CV_COUNT);

	logic [7:0]          mem [CV_COUNT];
	logic [CV_COUNT-1:0] vld_q;
	logic [7:0]          mem_s1;
	logic [7:0]          byp_data_s1;
	logic                byp_s1;
	logic                rd_vld_s1;
	logic                rd_in_range;
	logic                rd_fire;
	logic [AW-1:0]       ra;
	logic [AW-1:0]       wa;

	assign ra          = rd_addr[AW-1:0];
	assign wa          = wr.addr[AW-1:0];
	assign rd_in_range = ({1'b0, rd_addr} < 9'(CV_COUNT));
	assign rd_fire     = rd_en && rd_in_range;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wa] <= wr.data;
		end
		if (rd_fire) begin
			mem_s1 <= mem[ra];
		end
		if (rd_en) begin
			byp_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			byp_s1    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				byp_s1    <= wr.en && (wr.addr == rd_addr);
				rd_vld_s1 <= rd_fire && vld_q[ra];
			end
		end
	end

	assign rd_data = byp_s1 ? byp_data_s1 : (rd_vld_s1 ? mem_s1 : 8'd0);

endmodule

// ===== hdl/dcc_pid_decode.sv =====
// ---------------------------------------------------------------------------
// dcc_pid_decode
// packet decode: reset detection, service phase steps, direct-mode cv
// access and operations-mode instruction decode
// ---------------------------------------------------------------------------
module dcc_pid_decode #(
	parameter int CV_COUNT = dcc_pid_pkg::CV_COUNT_DEF
) (
	input  dcc_pid_pkg::pkt_t   pkt,
	input  dcc_pid_pkg::phase_t phase,
	input  logic [7:0]          highest_cv,
	input  logic [7:0]          cv_val,
	output dcc_pid_pkg::res_t   res,
	output dcc_pid_pkg::cv_wr_t wr,
	output dcc_pid_pkg::phase_t phase_nxt
);
	import dcc_pid_pkg::*;

	logic       is_reset;
	logic [7:0] cv_a;
	logic [7:0] cv_l;
	logic       ok_a;
	logic       ok_l;
	logic [2:0] pos;
	logic [7:0] bit_val;

	function automatic logic cv_ok(input logic [7:0] cv, input logic [7:0] hi);
		return (cv != 8'd0) && (cv <= hi) && ({1'b0, cv} < 9'(CV_COUNT));
	endfunction

	assign is_reset = (pkt.packet_size == SIZE_RESET) && (pkt.byte0 == 8'd0)
		&& (pkt.byte1 == 8'd0);
	assign cv_a = pkt.byte1 + 8'd1;
	assign cv_l = pkt.byte2 + 8'd1;
	assign ok_a = cv_ok(cv_a, highest_cv);
	assign ok_l = cv_ok(cv_l, highest_cv);
	assign pos  = pkt.byte2[2:0];

	always_comb begin
		bit_val      = cv_val;
		bit_val[pos] = pkt.byte2[3];
	end

	always_comb begin
		res       = '0;
		wr        = '0;
		phase_nxt = phase;
		if (is_reset) begin
			res.reset_seen = 1'b1;
			case (phase)
				PH_INACTIVE: phase_nxt = PH_POSSIBLE;
				PH_POSSIBLE: phase_nxt = PH_ACTIVE;
				default:     phase_nxt = phase;
			endcase
		end else begin
			case (phase)
				PH_POSSIBLE: begin
				end
				PH_ACTIVE: begin
					if ((pkt.packet_size == SIZE_SVC) && ((pkt.byte0 & SVC_MASK) == SVC_DIRECT)
						&& ok_a) begin
						case (pkt.byte0 & KIND_MASK)
							KIND_VERIFY: begin
								res.ack = (cv_val == pkt.byte2);
							end
							KIND_WRITE: begin
								wr      = '{en: 1'b1, addr: cv_a, data: pkt.byte2};
								res.ack = 1'b1;
							end
							KIND_BIT: begin
								if (pkt.byte2[4]) begin
									wr      = '{en: 1'b1, addr: cv_a, data: bit_val};
									res.ack = 1'b1;
								end else begin
									res.ack = (cv_val[pos] == pkt.byte2[3]);
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					case (pkt.byte1 & INSTR_MASK)
						INSTR_ADV: begin
							if ((pkt.byte1 & ADV_SUB_MASK) == ADV_SPEED128) begin
								res.speed_valid = 1'b1;
								res.speed_step  = pkt.byte2[6:0];
								res.forward     = pkt.byte2[7];
							end
						end
						INSTR_FG1: begin
							res.group1_valid  = 1'b1;
							res.function_byte = pkt.byte1;
						end
						INSTR_FG2: begin
							res.group2_valid  = 1'b1;
							res.function_byte = pkt.byte1;
						end
						INSTR_CV: begin
							if ((pkt.packet_size == SIZE_LONG) && ok_l
								&& ((pkt.byte1 & CV_OP_MASK) == CV_OP_WRITE)) begin
								wr = '{en: 1'b1, addr: cv_l, data: pkt.byte3};
							end
						end
						default: begin
						end
					endcase
				end
			endcase
		end
	end

endmodule
